// ----- rtl/transposition_table_probe_store_assert.svh -----
// Assertion macros shared by the table logic.
// Each macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef TRANSPOSITION_TABLE_PROBE_STORE_ASSERT_SVH
`define TRANSPOSITION_TABLE_PROBE_STORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTPS_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TTPS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ttps_pkg.sv -----
`timescale 1ns / 1ps

package ttps_pkg;

  // Table geometry. The entry count is a power of two, so the slot index is
  // the low bits of the key and the remaining bits form the tag.
  localparam int ENTRIES = 4096;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int KEY_W   = 64;
  localparam int TAG_W   = KEY_W - IDX_W;
  localparam int DEPTH_W = 7;
  localparam int SCORE_W = 32;

  // Generation mark stored with every entry; a clear moves to the next one.
  localparam int EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;

  // Operation codes.
  localparam logic [1:0] MODE_PROBE = 2'd0;
  localparam logic [1:0] MODE_STORE = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // Bound kinds.
  localparam logic [1:0] BOUND_EXACT = 2'd0;
  localparam logic [1:0] BOUND_UPPER = 2'd1;
  localparam logic [1:0] BOUND_LOWER = 2'd2;

  typedef enum logic {
    ST_SWEEP,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic [1:0]                mode;
    logic [KEY_W-1:0]          position_key;
    logic signed [DEPTH_W-1:0] search_depth;
    logic signed [SCORE_W-1:0] score_in;
    logic [1:0]                bound_kind;
    logic                      side_to_move;
    logic signed [SCORE_W-1:0] window_low;
    logic signed [SCORE_W-1:0] window_high;
  } item_t;

  typedef struct packed {
    logic                      score_found;
    logic signed [SCORE_W-1:0] score_out;
    logic                      entry_written;
  } result_t;

  typedef struct packed {
    logic                      valid;
    logic [EPOCH_W-1:0]        epoch;
    logic [TAG_W-1:0]          tag;
    logic signed [DEPTH_W-1:0] depth;
    logic signed [SCORE_W-1:0] score;
    logic [1:0]                bound;
    logic                      side;
  } entry_t;

  // What the decision logic asks of the table for one item.
  typedef struct packed {
    result_t res;
    logic    wr_en;
    entry_t  wr_entry;
    logic    clear;
  } action_t;

endpackage

// ----- rtl/ttps_if.sv -----
`timescale 1ns / 1ps

// Channel that carries one table operation.
interface ttps_req_if;
  logic                                        valid;
  logic                                        ready;
  logic [1:0]                                  mode;
  logic [ttps_pkg::KEY_W-1:0]                  position_key;
  logic signed [ttps_pkg::DEPTH_W-1:0]         search_depth;
  logic signed [ttps_pkg::SCORE_W-1:0]         score_in;
  logic [1:0]                                  bound_kind;
  logic                                        side_to_move;
  logic signed [ttps_pkg::SCORE_W-1:0]         window_low;
  logic signed [ttps_pkg::SCORE_W-1:0]         window_high;

  modport source (
    output valid, mode, position_key, search_depth, score_in, bound_kind,
           side_to_move, window_low, window_high,
    input  ready
  );

  modport sink (
    input  valid, mode, position_key, search_depth, score_in, bound_kind,
           side_to_move, window_low, window_high,
    output ready
  );
endinterface

// Channel that carries the outcome of one operation.
interface ttps_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                score_found;
  logic signed [ttps_pkg::SCORE_W-1:0] score_out;
  logic                                entry_written;

  modport source (
    output valid, score_found, score_out, entry_written,
    input  ready
  );

  modport sink (
    input  valid, score_found, score_out, entry_written,
    output ready
  );
endinterface

// ----- rtl/ttps_resolve.sv -----
`timescale 1ns / 1ps

// Decides the outcome of one item against the entry read from its slot:
// probe hit and score selection, depth-preferred replacement, and clear.
module ttps_resolve (
  input  ttps_pkg::item_t                   item,
  input  ttps_pkg::entry_t                  entry,
  input  logic [ttps_pkg::EPOCH_W-1:0]      epoch,
  output ttps_pkg::action_t                 act
);

  logic live;
  logic tag_match;
  logic hit;
  logic keep_resident;

  always_comb begin
    // An entry only counts when it was written since the last clear.
    live          = entry.valid && (entry.epoch == epoch);
    tag_match     = entry.tag == item.position_key[ttps_pkg::KEY_W-1:ttps_pkg::IDX_W];
    hit           = live && tag_match && (entry.depth >= item.search_depth) &&
                    (entry.side == item.side_to_move);
    keep_resident = live && (entry.depth > item.search_depth);

    act = '0;
    act.wr_entry.valid = 1'b1;
    act.wr_entry.epoch = epoch;
    act.wr_entry.tag   = item.position_key[ttps_pkg::KEY_W-1:ttps_pkg::IDX_W];
    act.wr_entry.depth = item.search_depth;
    act.wr_entry.score = item.score_in;
    act.wr_entry.bound = item.bound_kind;
    act.wr_entry.side  = item.side_to_move;

    case (item.mode)
      ttps_pkg::MODE_PROBE: begin
        if (hit) begin
          case (entry.bound)
            ttps_pkg::BOUND_EXACT: begin
              act.res.score_found = 1'b1;
              act.res.score_out   = entry.score;
            end
            ttps_pkg::BOUND_UPPER: begin
              if (entry.score <= item.window_low) begin
                act.res.score_found = 1'b1;
                act.res.score_out   = item.window_low;
              end
            end
            ttps_pkg::BOUND_LOWER: begin
              if (entry.score >= item.window_high) begin
                act.res.score_found = 1'b1;
                act.res.score_out   = item.window_high;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ttps_pkg::MODE_STORE: begin
        // Replace unless the resident entry searched deeper.
        if (!keep_resident) begin
          act.wr_en             = 1'b1;
          act.res.entry_written = 1'b1;
        end
      end
      ttps_pkg::MODE_CLEAR: begin
        act.clear = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/transposition_table_probe_store.sv -----
`timescale 1ns / 1ps
// Direct-mapped transposition table of 4096 entries with depth-preferred
// replacement. Each item is a probe, a store or a clear and gives exactly one
// result item. The table is one synchronous memory with a single read and a
// single write port: an item reads its slot in the cycle it is accepted, is
// decided and written back in the decision stage, and its result is then held
// in the output register. One item is taken every cycle while the result side
// keeps up. A write is forwarded to the following item that reads the same
// slot. A clear moves to a new generation mark, but every 256th clear, and
// reset, run a clearing pass through all 4096 slots of the memory during
// which no item is accepted.
`include "transposition_table_probe_store_assert.svh"

module transposition_table_probe_store (
  input logic           clk,
  input logic           rst,
  ttps_req_if.sink      req,
  ttps_rsp_if.source    rsp
);

  ttps_pkg::state_t                   state;
  ttps_pkg::state_t                   state_next;
  logic [ttps_pkg::IDX_W-1:0]         sweep_cnt;
  logic [ttps_pkg::EPOCH_W-1:0]       epoch;

  logic                               req_fire;
  logic                               wrap_hold;
  logic                               s1_valid;
  logic                               s1_adv;
  ttps_pkg::item_t                    s1_item;
  ttps_pkg::item_t                    req_item;
  logic [ttps_pkg::IDX_W-1:0]         s1_idx;

  ttps_pkg::entry_t                   mem [ttps_pkg::ENTRIES];
  ttps_pkg::entry_t                   rd_entry;
  ttps_pkg::entry_t                   cur_entry;
  logic                               mem_we;
  logic [ttps_pkg::IDX_W-1:0]         mem_waddr;
  ttps_pkg::entry_t                   mem_wdata;

  logic                               fwd_valid;
  logic [ttps_pkg::IDX_W-1:0]         fwd_idx;
  ttps_pkg::entry_t                   fwd_entry;

  ttps_pkg::action_t                  act;
  logic                               sweep_start;

  // Gather the incoming payload into one item.
  always_comb begin
    req_item.mode         = req.mode;
    req_item.position_key = req.position_key;
    req_item.search_depth = req.search_depth;
    req_item.score_in     = req.score_in;
    req_item.bound_kind   = req.bound_kind;
    req_item.side_to_move = req.side_to_move;
    req_item.window_low   = req.window_low;
    req_item.window_high  = req.window_high;
  end

  // Handshake and stage control. A clear that wraps the generation mark
  // holds the input so that no item reads the table ahead of the sweep.
  assign s1_adv      = s1_valid && (!rsp.valid || rsp.ready);
  assign wrap_hold   = s1_valid && (s1_item.mode == ttps_pkg::MODE_CLEAR) &&
                       (epoch == ttps_pkg::EPOCH_LAST);
  assign req.ready   = (state == ttps_pkg::ST_RUN) && !wrap_hold &&
                       (!s1_valid || s1_adv);
  assign req_fire    = req.valid && req.ready;
  assign s1_idx      = s1_item.position_key[ttps_pkg::IDX_W-1:0];
  assign sweep_start = s1_adv && act.clear && (epoch == ttps_pkg::EPOCH_LAST);

  // Table memory: registered read on accept, one write port.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      rd_entry <= mem[req.position_key[ttps_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // The sweep owns the write port; otherwise a store writes back its slot.
  always_comb begin
    if (state == ttps_pkg::ST_SWEEP) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_cnt;
      mem_wdata = '0;
    end else begin
      mem_we    = s1_adv && act.wr_en;
      mem_waddr = s1_idx;
      mem_wdata = act.wr_entry;
    end
  end

  // The last write is forwarded when it went to the slot now being decided.
  assign cur_entry = (fwd_valid && (fwd_idx == s1_idx)) ? fwd_entry : rd_entry;

  ttps_resolve u_resolve (
    .item  (s1_item),
    .entry (cur_entry),
    .epoch (epoch),
    .act   (act)
  );

  // Decision stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1_item <= req_item;
    end
  end

  // Forwarding register for the most recent store.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (state == ttps_pkg::ST_SWEEP) begin
      fwd_valid <= 1'b0;
    end else if (s1_adv && act.wr_en) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && act.wr_en) begin
      fwd_idx   <= s1_idx;
      fwd_entry <= act.wr_entry;
    end
  end

  // Generation mark: a clear moves on; a wrapping clear returns it to zero and the sweep follows.
  always_ff @(posedge clk) begin
    if (rst) begin
      epoch <= '0;
    end else if (s1_adv && act.clear) begin
      epoch <= epoch + 1'b1;
    end
  end

  // Sweep counter walks every slot once per pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (state == ttps_pkg::ST_SWEEP) begin
      sweep_cnt <= sweep_cnt + 1'b1;
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ttps_pkg::ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  // Next state: sweep after reset and after a wrapping clear.
  always_comb begin
    state_next = state;
    case (state)
      ttps_pkg::ST_SWEEP: begin
        if (sweep_cnt == ttps_pkg::IDX_W'(ttps_pkg::ENTRIES - 1)) begin
          state_next = ttps_pkg::ST_RUN;
        end
      end
      ttps_pkg::ST_RUN: begin
        if (sweep_start) begin
          state_next = ttps_pkg::ST_SWEEP;
        end
      end
      default: begin
        state_next = ttps_pkg::ST_SWEEP;
      end
    endcase
  end

  // Output register; it frees up in the cycle its item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (s1_adv) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp.score_found   <= act.res.score_found;
      rsp.score_out     <= act.res.score_out;
      rsp.entry_written <= act.res.entry_written;
    end
  end

  // Checks on sweep, write port and generation mark.
  `TTPS_ASSERT_SAME(a_no_accept_in_sweep, state == ttps_pkg::ST_SWEEP, !req_fire, "item accepted during clearing pass")
  `TTPS_ASSERT_SAME(a_sweep_epoch_zero, state == ttps_pkg::ST_SWEEP, epoch == '0, "generation mark not restarted during clearing pass")
  `TTPS_ASSERT_NEXT(a_wrap_starts_sweep, sweep_start, state == ttps_pkg::ST_SWEEP, "wrapping clear did not start a clearing pass")
  `TTPS_ASSERT_SAME(a_write_source, mem_we, (state == ttps_pkg::ST_SWEEP) || (s1_adv && (s1_item.mode == ttps_pkg::MODE_STORE)), "table written outside a store or sweep")
  `TTPS_ASSERT_SAME(a_no_stage_in_sweep, state == ttps_pkg::ST_SWEEP, !s1_valid, "item in flight during clearing pass")

endmodule

// ----- sim/transposition_table_probe_store_tb.sv -----
`timescale 1ns / 1ps

module transposition_table_probe_store_tb;
  import ttps_pkg::*;

  // Codes that the package leaves unnamed: the spare operation and bound kind.
  localparam logic [1:0] MODE_NONE  = 2'd3;
  localparam logic [1:0] BOUND_NONE = 2'd3;

  localparam logic signed [DEPTH_W-1:0] DEPTH_MIN      = 7'sh40;
  localparam logic signed [DEPTH_W-1:0] DEPTH_MAX      = 7'sh3F;
  localparam logic signed [SCORE_W-1:0] SCORE_MIN      = 32'sh8000_0000;
  localparam logic signed [SCORE_W-1:0] SCORE_MAX      = 32'sh7FFF_FFFF;
  localparam logic signed [SCORE_W-1:0] SCORE_SENTINEL = -32'sd9999999;
  localparam logic [KEY_W-1:0]          KEY_ONES       = '1;
  localparam logic [KEY_W-1:0]          KEY_ALT        = {1'b0, {(KEY_W-1){1'b1}}};

  // Shadow copy of the table that predicts the outcome of every operation
  // and checks the outcomes that come back, oldest first.
  class slot_mirror;
    bit                        live [ENTRIES];
    logic [KEY_W-1:0]          key_tab [ENTRIES];
    logic signed [DEPTH_W-1:0] depth_tab [ENTRIES];
    logic signed [SCORE_W-1:0] score_tab [ENTRIES];
    logic [1:0]                bound_tab [ENTRIES];
    logic                      side_tab [ENTRIES];
    result_t                   due_outcomes [$];
    int unsigned               mismatches;

    function new();
      foreach (live[i]) live[i] = 1'b0;
      mismatches = 0;
    endfunction

    // Apply one accepted operation to the shadow table and queue its outcome.
    function void note_op(item_t op);
      result_t                   res;
      logic [IDX_W-1:0]          slot;
      logic signed [SCORE_W-1:0] held;
      res  = '0;
      slot = op.position_key[IDX_W-1:0];
      held = score_tab[slot];
      case (op.mode)
        MODE_PROBE: begin
          if (live[slot] && key_tab[slot] == op.position_key &&
              depth_tab[slot] >= op.search_depth &&
              side_tab[slot] == op.side_to_move) begin
            if (bound_tab[slot] == BOUND_EXACT) begin
              res.score_found = 1'b1;
              res.score_out   = held;
            end else if (bound_tab[slot] == BOUND_UPPER && held <= op.window_low) begin
              res.score_found = 1'b1;
              res.score_out   = op.window_low;
            end else if (bound_tab[slot] == BOUND_LOWER && held >= op.window_high) begin
              res.score_found = 1'b1;
              res.score_out   = op.window_high;
            end
          end
        end
        MODE_STORE: begin
          // An empty slot is always taken; a resident entry only yields to
          // a store of equal or greater depth.
          if (!live[slot] || depth_tab[slot] <= op.search_depth) begin
            live[slot]      = 1'b1;
            key_tab[slot]   = op.position_key;
            depth_tab[slot] = op.search_depth;
            score_tab[slot] = op.score_in;
            bound_tab[slot] = op.bound_kind;
            side_tab[slot]  = op.side_to_move;
            res.entry_written = 1'b1;
          end
        end
        MODE_CLEAR: begin
          foreach (live[i]) live[i] = 1'b0;
        end
        default: begin
        end
      endcase
      due_outcomes.push_back(res);
    endfunction

    // Compare one accepted outcome with the oldest prediction.
    function void check_outcome(result_t got);
      result_t want;
      if (due_outcomes.size() == 0) begin
        $error("result item arrived with no operation outstanding");
        mismatches++;
      end else begin
        want = due_outcomes.pop_front();
        if (got.score_found !== want.score_found) begin
          $error("score_found expected %0d actual %0d", want.score_found, got.score_found);
          mismatches++;
        end
        if (got.score_out !== want.score_out) begin
          $error("score_out expected %0d actual %0d", want.score_out, got.score_out);
          mismatches++;
        end
        if (got.entry_written !== want.entry_written) begin
          $error("entry_written expected %0d actual %0d",
                 want.entry_written, got.entry_written);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  ttps_req_if req ();
  ttps_rsp_if rsp ();

  transposition_table_probe_store uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  slot_mirror  book;
  bit          calm = 1'b0;
  int unsigned ops_sent = 0;
  int unsigned clears_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic item_t make_op(logic [1:0] mode, logic [KEY_W-1:0] key,
                                    logic signed [DEPTH_W-1:0] depth,
                                    logic signed [SCORE_W-1:0] score,
                                    logic [1:0] bound, logic side,
                                    logic signed [SCORE_W-1:0] lo,
                                    logic signed [SCORE_W-1:0] hi);
    item_t op;
    op.mode         = mode;
    op.position_key = key;
    op.search_depth = depth;
    op.score_in     = score;
    op.bound_kind   = bound;
    op.side_to_move = side;
    op.window_low   = lo;
    op.window_high  = hi;
    return op;
  endfunction

  // Scores lean towards the extremes and the engine's no-score sentinel.
  function automatic logic signed [SCORE_W-1:0] rand_score();
    case ($urandom_range(15))
      0:       return SCORE_MIN;
      1:       return SCORE_MAX;
      2:       return SCORE_SENTINEL;
      default: return $urandom;
    endcase
  endfunction

  // Keys often land on a handful of busy slots so that tags collide.
  function automatic logic [KEY_W-1:0] rand_key();
    logic [KEY_W-1:0] k;
    k = {$urandom, $urandom};
    case ($urandom_range(9))
      0:          k = '0;
      1:          k = KEY_ONES;
      2, 3, 4, 5: k[IDX_W-1:0] = IDX_W'($urandom_range(7) * 511);
      default:    ;
    endcase
    return k;
  endfunction

  // A probe aimed at a stored item: depth and window sit on the edges of
  // the comparisons, and now and then the key or the side is off by one bit.
  function automatic item_t probe_of(item_t s);
    item_t p;
    p = s;
    p.mode = MODE_PROBE;
    if ($urandom_range(9) == 0)
      p.position_key = s.position_key ^ (64'd1 << $urandom_range(KEY_W-1));
    p.search_depth = s.search_depth + 7'($urandom_range(2)) - 7'd1;
    if ($urandom_range(99) < 15)
      p.side_to_move = ~s.side_to_move;
    p.window_low  = ($urandom_range(9) < 6) ? s.score_in + 32'($urandom_range(2)) - 32'd1
                                            : rand_score();
    p.window_high = ($urandom_range(9) < 6) ? s.score_in + 32'($urandom_range(2)) - 32'd1
                                            : rand_score();
    return p;
  endfunction

  // Present one item, with a random gap in front, and hold it until taken.
  task automatic send_op(item_t op);
    while (!calm && $urandom_range(99) < 37) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.mode         <= op.mode;
    req.position_key <= op.position_key;
    req.search_depth <= op.search_depth;
    req.score_in     <= op.score_in;
    req.bound_kind   <= op.bound_kind;
    req.side_to_move <= op.side_to_move;
    req.window_low   <= op.window_low;
    req.window_high  <= op.window_high;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    book.note_op(op);
    ops_sent++;
    if (op.mode == MODE_CLEAR) clears_sent++;
  endtask

  // Stop sending until every predicted outcome has come back.
  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (book.due_outcomes.size() != 0) @(posedge clk);
  endtask

  // Result side: take outcomes and stall at random.
  initial begin : result_taker
    result_t got;
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready) begin
        got.score_found   = rsp.score_found;
        got.score_out     = rsp.score_out;
        got.entry_written = rsp.entry_written;
        book.check_outcome(got);
      end
      rsp.ready <= !rst && (calm || $urandom_range(99) >= 37);
    end
  end

  initial begin : stimulus
    item_t       op;
    item_t       rival;
    item_t       stored [$];
    int unsigned kind;
    int unsigned reps;
    bit          drained_mid;
    book = new();
    drained_mid      = 1'b0;
    req.valid        = 1'b0;
    req.mode         = MODE_PROBE;
    req.position_key = '0;
    req.search_depth = '0;
    req.score_in     = '0;
    req.bound_kind   = BOUND_EXACT;
    req.side_to_move = 1'b0;
    req.window_low   = '0;
    req.window_high  = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty slot, field extremes, each bound kind, depth and side
    // refusals, tag collision, equal-depth replacement, spare codes, clear.
    send_op(make_op(MODE_PROBE, '0, DEPTH_MIN, '0, BOUND_EXACT, 1'b0, '0, '0));
    send_op(make_op(MODE_STORE, '0, DEPTH_MIN, SCORE_MIN, BOUND_EXACT, 1'b0, '0, '0));
    send_op(make_op(MODE_PROBE, '0, DEPTH_MIN, '0, BOUND_EXACT, 1'b0, '0, '0));
    send_op(make_op(MODE_PROBE, '0, DEPTH_MIN + 7'sd1, '0, BOUND_EXACT, 1'b0, '0, '0));
    send_op(make_op(MODE_PROBE, '0, DEPTH_MIN, '0, BOUND_EXACT, 1'b1, '0, '0));
    send_op(make_op(MODE_STORE, KEY_ONES, DEPTH_MAX, SCORE_MAX, BOUND_LOWER, 1'b1,
                    '0, '0));
    send_op(make_op(MODE_PROBE, KEY_ONES, DEPTH_MAX, '0, BOUND_EXACT, 1'b1,
                    SCORE_MIN, SCORE_MAX));
    send_op(make_op(MODE_PROBE, KEY_ONES, DEPTH_MIN, '0, BOUND_EXACT, 1'b1,
                    SCORE_MAX, SCORE_MIN));
    send_op(make_op(MODE_STORE, KEY_ONES, DEPTH_MAX - 7'sd1, '0, BOUND_EXACT, 1'b1,
                    '0, '0));
    send_op(make_op(MODE_STORE, KEY_ALT, DEPTH_MAX, SCORE_SENTINEL, BOUND_UPPER, 1'b0,
                    '0, '0));
    send_op(make_op(MODE_PROBE, KEY_ONES, DEPTH_MIN, '0, BOUND_EXACT, 1'b1, '0, '0));
    send_op(make_op(MODE_PROBE, KEY_ALT, DEPTH_MAX, '0, BOUND_EXACT, 1'b0,
                    SCORE_SENTINEL, '0));
    send_op(make_op(MODE_PROBE, KEY_ALT, DEPTH_MAX, '0, BOUND_EXACT, 1'b0,
                    SCORE_SENTINEL - 32'sd1, '0));
    send_op(make_op(MODE_PROBE, KEY_ALT, DEPTH_MAX, '0, BOUND_EXACT, 1'b0,
                    SCORE_MAX, SCORE_MIN));
    send_op(make_op(MODE_STORE, 64'd5, '0, 32'sd7, BOUND_NONE, 1'b0, '0, '0));
    send_op(make_op(MODE_PROBE, 64'd5, '0, '0, BOUND_EXACT, 1'b0, SCORE_MAX, SCORE_MIN));
    send_op(make_op(MODE_NONE, KEY_ONES, DEPTH_MAX, SCORE_MAX, BOUND_NONE, 1'b1,
                    SCORE_MAX, SCORE_MAX));
    send_op(make_op(MODE_CLEAR, '0, '0, '0, BOUND_EXACT, 1'b0, '0, '0));
    send_op(make_op(MODE_PROBE, '0, DEPTH_MIN, '0, BOUND_EXACT, 1'b0, '0, '0));
    send_op(make_op(MODE_STORE, KEY_ALT, DEPTH_MIN, SCORE_SENTINEL, BOUND_EXACT, 1'b0,
                    '0, '0));
    send_op(make_op(MODE_PROBE, KEY_ALT, DEPTH_MIN, '0, BOUND_EXACT, 1'b0, '0, '0));
    drain();

    // Random: stores followed by probes aimed at them (the most common kind),
    // probes of older stores, bursts of clears (enough to wrap the generation
    // mark) and some fully random items.
    while (ops_sent < 820 || clears_sent < 270) begin
      calm = (ops_sent >= 270 && ops_sent < 420);
      if (!drained_mid && ops_sent >= 570) begin
        drain();
        drained_mid = 1'b1;
      end
      kind = $urandom_range(99);
      if (kind < 45) begin
        op = make_op(MODE_STORE, rand_key(), 7'($urandom_range(127)), rand_score(),
                     ($urandom_range(9) == 0) ? BOUND_NONE : 2'($urandom_range(2)),
                     1'($urandom_range(1)), rand_score(), rand_score());
        send_op(op);
        stored.push_back(op);
        if (stored.size() > 16) void'(stored.pop_front());
        // Sometimes a second store competes for the same slot.
        if ($urandom_range(9) < 3) begin
          rival = op;
          if ($urandom_range(1) == 1)
            rival.position_key[KEY_W-1:IDX_W] = TAG_W'({$urandom, $urandom});
          rival.search_depth = op.search_depth + 7'($urandom_range(2)) - 7'd1;
          rival.score_in     = rand_score();
          send_op(rival);
        end
        reps = $urandom_range(1, 3);
        repeat (reps) send_op(probe_of(op));
      end else if (kind < 65 && stored.size() != 0) begin
        send_op(probe_of(stored[$urandom_range(stored.size() - 1)]));
      end else if (kind < 75) begin
        reps = $urandom_range(1, 16);
        repeat (reps)
          send_op(make_op(MODE_CLEAR, rand_key(), 7'($urandom_range(127)), rand_score(),
                          2'($urandom_range(3)), 1'($urandom_range(1)),
                          rand_score(), rand_score()));
      end else begin
        send_op(make_op(2'($urandom_range(3)), rand_key(), 7'($urandom_range(127)),
                        rand_score(), 2'($urandom_range(3)), 1'($urandom_range(1)),
                        rand_score(), rand_score()));
      end
    end
    calm = 1'b0;

    drain();
    repeat (16) @(posedge clk);
    if (book.mismatches == 0 && book.due_outcomes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, clearing passes included.
  initial begin : watchdog
    #(3_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
